// ===== design/btlv_pkg.sv =====
package btlv_pkg;

    typedef enum logic [2:0] {
        PH_TAG    = 3'd0,
        PH_LEN    = 3'd1,
        PH_L81    = 3'd2,
        PH_L82HI  = 3'd3,
        PH_L82LO  = 3'd4,
        PH_VALUE  = 3'd5,
        PH_SKIP   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_TAG   = 2'd0,
        ROLE_LEN   = 2'd1,
        ROLE_VALUE = 2'd2,
        ROLE_SKIP  = 2'd3
    } t_role;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_INVAL = 2'd2
    } t_status;

    localparam logic [7:0] LEN_LONG1 = 8'h81;
    localparam logic [7:0] LEN_LONG2 = 8'h82;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  tag;
        logic [15:0] len;
        logic [15:0] count;
        t_status     err;
    } t_state;

    typedef struct packed {
        t_role       role;
        logic [7:0]  tag;
        logic [15:0] vlen;
        logic [15:0] voff;
        logic        done;
        t_status     status;
        logic        buffer_done;
    } t_result;

endpackage

// ===== design/btlv_if.sv =====
interface btlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface btlv_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  byte_role;
    logic [7:0]  entry_tag;
    logic [15:0] value_len;
    logic [15:0] value_offset;
    logic        entry_done;
    logic [1:0]  status;
    logic        buffer_done;

    modport source (
        output valid, output byte_role, output entry_tag, output value_len,
        output value_offset, output entry_done, output status, output buffer_done,
        input ready
    );
    modport sink (
        input valid, input byte_role, input entry_tag, input value_len,
        input value_offset, input entry_done, input status, input buffer_done,
        output ready
    );
endinterface

// ===== design/ber_tlv_stream_parser.sv =====
// Path: with the result register free, an accepted byte is registered in the input register and
// then in the result register. The parse state loops once per byte through the decoder.
// Throughput: one byte per cycle while the result is not stalled.
// Input and result registers decouple the two sides; while a result is stalled one more
// request is taken into the input register, after which input ready drops.
// Reset (synchronous, active low) empties both registers and returns the parser to tag.
module ber_tlv_stream_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    btlv_in_if.sink           i_in,
    btlv_out_if.source        o_out
);
    import btlv_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    logic       w_adv;
    logic       w_take;

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_take     = i_in.valid && i_in.ready;

    btlv_decode u_decode (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_next   (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_TAG, tag: 8'd0, len: 16'd0, count: 16'd0, err: ST_OK};
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.byte_role    = r_out.role;
    assign o_out.entry_tag    = r_out.tag;
    assign o_out.value_len    = r_out.vlen;
    assign o_out.value_offset = r_out.voff;
    assign o_out.entry_done   = r_out.done;
    assign o_out.status       = r_out.status;
    assign o_out.buffer_done  = r_out.buffer_done;

`ifndef NO_ASSERTIONS
    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done |-> r_out.status == ST_OK)
        else $error("entry completed with error status");

    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_last |=> r_state.phase == PH_TAG && r_state.err == ST_OK)
        else $error("parser not restarted after last byte");

    a_skip_inval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.role == ROLE_SKIP |-> r_out.status == ST_INVAL)
        else $error("skipped byte without invalid status");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.role == ROLE_VALUE |-> r_out.voff < r_out.vlen)
        else $error("value offset beyond value length");
`endif

endmodule

// ===== design/btlv_decode.sv =====
module btlv_decode (
    input  btlv_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output btlv_pkg::t_state  o_next,
    output btlv_pkg::t_result o_result
);
    import btlv_pkg::*;

    t_state      w_next;
    t_result     w_res;
    logic        w_complete;
    logic [15:0] w_len;
    logic [15:0] w_count_inc;

    assign w_count_inc = i_state.count + 16'd1;

    always_comb begin
        w_next      = i_state;
        w_complete  = 1'b0;
        w_len       = 16'd0;
        w_res.role        = ROLE_TAG;
        w_res.tag         = i_state.tag;
        w_res.vlen        = 16'd0;
        w_res.voff        = 16'd0;
        w_res.done        = 1'b0;
        w_res.status      = ST_OK;
        w_res.buffer_done = i_last;

        unique case (i_state.phase)
            PH_LEN: begin
                w_res.role = ROLE_LEN;
                if (!i_byte[7]) begin
                    w_complete = 1'b1;
                    w_len      = {8'd0, i_byte};
                end else if (i_byte == LEN_LONG1) begin
                    w_next.phase = PH_L81;
                    if (i_last) w_res.status = ST_SHORT;
                end else if (i_byte == LEN_LONG2) begin
                    w_next.phase = PH_L82HI;
                    if (i_last) w_res.status = ST_SHORT;
                end else begin
                    w_res.status = ST_INVAL;
                    w_next.err   = ST_INVAL;
                    w_next.phase = PH_SKIP;
                end
            end
            PH_L81: begin
                w_res.role = ROLE_LEN;
                w_complete = 1'b1;
                w_len      = {8'd0, i_byte};
            end
            PH_L82HI: begin
                w_res.role   = ROLE_LEN;
                w_next.len   = {i_byte, 8'd0};
                w_next.phase = PH_L82LO;
                if (i_last) w_res.status = ST_SHORT;
            end
            PH_L82LO: begin
                w_res.role = ROLE_LEN;
                w_complete = 1'b1;
                w_len      = {i_state.len[15:8], i_byte};
            end
            PH_VALUE: begin
                w_res.role   = ROLE_VALUE;
                w_res.vlen   = i_state.len;
                w_res.voff   = i_state.count;
                w_next.count = w_count_inc;
                if (w_count_inc >= i_state.len) begin
                    w_res.done   = 1'b1;
                    w_next.phase = PH_TAG;
                end else if (i_last) begin
                    w_res.status = ST_SHORT;
                end
            end
            PH_SKIP: begin
                w_res.role   = ROLE_SKIP;
                w_res.status = i_state.err;
            end
            default: begin
                w_next.tag   = i_byte;
                w_next.len   = 16'd0;
                w_next.count = 16'd0;
                w_next.phase = PH_LEN;
                w_res.tag    = i_byte;
                if (i_last) w_res.status = ST_SHORT;
            end
        endcase

        if (w_complete) begin
            w_res.vlen   = w_len;
            w_next.len   = w_len;
            w_next.count = 16'd0;
            if (w_len == 16'd0) begin
                w_res.done   = 1'b1;
                w_next.phase = PH_TAG;
            end else begin
                w_next.phase = PH_VALUE;
                if (i_last) w_res.status = ST_SHORT;
            end
        end

        if (i_last) begin
            w_next.phase = PH_TAG;
            w_next.len   = 16'd0;
            w_next.count = 16'd0;
            w_next.err   = ST_OK;
        end
    end

    assign o_next   = w_next;
    assign o_result = w_res;

endmodule
